### src/rbs_pkg.sv
// Shared constants, types and the constant-divisor mean for the 3x3 box smoother.
`timescale 1ns / 1ps

package rbs_pkg;

   localparam int MAX_DIM   = 1024;
   localparam int ADDR_W    = $clog2(MAX_DIM);
   localparam int POS_W     = 10;
   localparam int SIZE_W    = 11;
   localparam int CHAN_W    = 16;
   localparam int PIX_W     = 3 * CHAN_W;
   localparam int SUM_W     = 20;
   localparam int PROD_W    = 41;
   localparam int SIZE_RST  = 64;

   // Reciprocal constants: floor(s/9) = (s*M9) >> 24, floor(s/3) = (s*M3) >> 22
   localparam logic [20:0] M9 = 21'd1864136;
   localparam logic [20:0] M3 = 21'd1398102;
   localparam int SH9 = 24;
   localparam int SH3 = 22;

   typedef enum logic [2:0] {
      DIV_1,
      DIV_2,
      DIV_3,
      DIV_4,
      DIV_6,
      DIV_9
   } div_type;

   typedef logic [SUM_W-1:0] sum3_type [3];

   function automatic div_type div_code(input logic [1:0] rlo, input logic [1:0] clo);
      logic [3:0] cnt;
      div_type    d;
      cnt = 4'(2'd3 - rlo) * 4'(2'd3 - clo);
      unique case (cnt)
         4'd9:    d = DIV_9;
         4'd6:    d = DIV_6;
         4'd4:    d = DIV_4;
         4'd3:    d = DIV_3;
         4'd2:    d = DIV_2;
         default: d = DIV_1;
      endcase
      return d;
   endfunction

   function automatic logic [CHAN_W-1:0] div_mean(input logic [SUM_W-1:0] s, input div_type d);
      logic [PROD_W-1:0] p;
      logic [CHAN_W-1:0] q;
      p = '0;
      unique case (d)
         DIV_9: begin
            p = PROD_W'(s) * PROD_W'(M9);
            q = CHAN_W'(p >> SH9);
         end
         DIV_6: begin
            p = PROD_W'(s >> 1) * PROD_W'(M3);
            q = CHAN_W'(p >> SH3);
         end
         DIV_3: begin
            p = PROD_W'(s) * PROD_W'(M3);
            q = CHAN_W'(p >> SH3);
         end
         DIV_4:   q = CHAN_W'(s >> 2);
         DIV_2:   q = CHAN_W'(s >> 1);
         default: q = CHAN_W'(s);
      endcase
      return q;
   endfunction

endpackage

### src/rgb_box_smooth_3x3.sv
// Top level: streaming 3x3 box-mean smoother for a square RGB image.
`timescale 1ns / 1ps

// Channel | Dir | Handshake              | Contents
// req     | in  | req_tvalid/req_tready  | tdata: red, green, blue
// rsp     | out | rsp_tvalid/rsp_tready  | tdata: out_red, out_green, out_blue, out_row,
//         |     |                        | out_col; tlast: last_of_run
// csr     | in  | csr_valid/csr_ready    | csr_data: image_size
//
// One pixel a clock: a pixel is registered together with its line-store read, then
// its window sums are formed; results leave one a clock, unless rsp_tready holds them,
// through a divide stage into the output register. Up to four results per pixel
// (row and frame ends) take one rsp transfer each, and the input stalls only while
// those drain. Reset clears control state only; line-store entries never written
// are always clipped out of the window.

module rgb_box_smooth_3x3 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // red [15:0], green [31:16], blue [47:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // out_red, out_green, out_blue, out_row, out_col, 0 pad
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [10:0] csr_data
);

   localparam int CW = rbs_pkg::CHAN_W;
   localparam int PW = rbs_pkg::PIX_W;
   localparam int AW = rbs_pkg::ADDR_W;
   localparam int QW = rbs_pkg::POS_W;
   localparam int SW = rbs_pkg::SUM_W;

   // configuration
   logic [rbs_pkg::SIZE_W-1:0] size_ff;
   logic [rbs_pkg::SIZE_W-1:0] eff_n;

   // position counters
   logic [QW-1:0] row_ff, col_ff, row_in, col_in, cur_r, cur_c;

   // line stores: {older, newer} at one address
   logic [2*PW-1:0] line_mem [rbs_pkg::MAX_DIM];
   logic [2*PW-1:0] line_rd_ff;

   // stage 1: pixel plus line read
   logic          s1_valid_ff;
   logic [PW-1:0] s1_pix_ff;
   logic [QW-1:0] s1_r_ff, s1_c_ff;
   logic [3:0]    s1_emit_ff;
   logic [3:0]    emit_in;
   logic [PW-1:0] win_ff [6];

   // stage 2: pending results
   logic [3:0]      s2_mask_ff;
   rbs_pkg::sum3_type s2_sum_ff [4];
   rbs_pkg::div_type  s2_div_ff [4];
   logic [QW-1:0]   s2_row_ff [4];
   logic [QW-1:0]   s2_col_ff [4];

   rbs_pkg::sum3_type sum_in [4];
   rbs_pkg::div_type  div_in [4];
   logic [QW-1:0]   orow_in [4];
   logic [QW-1:0]   ocol_in [4];
   logic [PW-1:0]   grid [3][3];
   logic [1:0]      rlo_prev, rlo_cur, clo_prev, clo_cur;
   logic [1:0]      rlo_s [4];
   logic [1:0]      clo_s [4];

   // output register
   logic          rsp_valid_ff;
   logic [CW-1:0] o_red_ff, o_green_ff, o_blue_ff;
   logic [QW-1:0] o_row_ff, o_col_ff;
   logic          o_last_ff;

   logic       accept, s1_adv, rsp_load, s2_free;
   logic [1:0] pick;
   logic [3:0] mask_left;

   assign csr_ready = 1'b1;

   always_comb begin
      if (size_ff == '0) begin
         eff_n = rbs_pkg::SIZE_W'(1);
      end else if (size_ff > rbs_pkg::SIZE_W'(rbs_pkg::MAX_DIM)) begin
         eff_n = rbs_pkg::SIZE_W'(rbs_pkg::MAX_DIM);
      end else begin
         eff_n = size_ff;
      end
   end

   // restart a frame whose size shrank under the counters
   always_comb begin
      if ({1'b0, row_ff} >= eff_n || {1'b0, col_ff} >= eff_n) begin
         cur_r = '0;
         cur_c = '0;
      end else begin
         cur_r = row_ff;
         cur_c = col_ff;
      end
      emit_in[0] = (cur_r != '0) && (cur_c != '0);
      emit_in[1] = (cur_r != '0) && ({1'b0, cur_c} == eff_n - 1'b1);
      emit_in[2] = ({1'b0, cur_r} == eff_n - 1'b1) && (cur_c != '0);
      emit_in[3] = ({1'b0, cur_r} == eff_n - 1'b1) && ({1'b0, cur_c} == eff_n - 1'b1);
      if ({1'b0, cur_c} + 1'b1 >= eff_n) begin
         col_in = '0;
         row_in = ({1'b0, cur_r} + 1'b1 >= eff_n) ? '0 : cur_r + 1'b1;
      end else begin
         col_in = cur_c + 1'b1;
         row_in = cur_r;
      end
   end

   // handshake chain
   always_comb begin
      priority if (s2_mask_ff[0]) pick = 2'd0;
      else if (s2_mask_ff[1])     pick = 2'd1;
      else if (s2_mask_ff[2])     pick = 2'd2;
      else                        pick = 2'd3;
      mask_left       = s2_mask_ff;
      mask_left[pick] = 1'b0;
      rsp_load   = (s2_mask_ff != '0) && (!rsp_valid_ff || rsp_tready);
      s2_free    = (s2_mask_ff == '0) || (rsp_load && mask_left == '0);
      s1_adv     = s1_valid_ff && s2_free;
      req_tready = !s1_valid_ff || s1_adv;
      accept     = req_tvalid && req_tready;
   end

   // window sums for the four candidate results
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         grid[r][0] = win_ff[r];
         grid[r][1] = win_ff[3+r];
      end
      grid[0][2] = line_rd_ff[2*PW-1:PW];
      grid[1][2] = line_rd_ff[PW-1:0];
      grid[2][2] = s1_pix_ff;
      rlo_prev = (s1_r_ff == QW'(1)) ? 2'd1 : 2'd0;
      rlo_cur  = (s1_r_ff == '0)     ? 2'd2 : 2'd1;
      clo_prev = (s1_c_ff == QW'(1)) ? 2'd1 : 2'd0;
      clo_cur  = (s1_c_ff == '0)     ? 2'd2 : 2'd1;
      rlo_s[0] = rlo_prev; clo_s[0] = clo_prev;
      rlo_s[1] = rlo_prev; clo_s[1] = clo_cur;
      rlo_s[2] = rlo_cur;  clo_s[2] = clo_prev;
      rlo_s[3] = rlo_cur;  clo_s[3] = clo_cur;
      orow_in[0] = s1_r_ff - 1'b1; ocol_in[0] = s1_c_ff - 1'b1;
      orow_in[1] = s1_r_ff - 1'b1; ocol_in[1] = s1_c_ff;
      orow_in[2] = s1_r_ff;        ocol_in[2] = s1_c_ff - 1'b1;
      orow_in[3] = s1_r_ff;        ocol_in[3] = s1_c_ff;
      for (int j = 0; j < 4; j++) begin
         div_in[j] = rbs_pkg::div_code(rlo_s[j], clo_s[j]);
         for (int k = 0; k < 3; k++) begin
            sum_in[j][k] = '0;
            for (int r = 0; r < 3; r++) begin
               for (int c = 0; c < 3; c++) begin
                  if (2'(r) >= rlo_s[j] && 2'(c) >= clo_s[j]) begin
                     sum_in[j][k] = sum_in[j][k] + SW'(grid[r][c][k*CW +: CW]);
                  end
               end
            end
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= rbs_pkg::SIZE_W'(rbs_pkg::SIZE_RST);
         row_ff       <= '0;
         col_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         s2_mask_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 6; i++) win_ff[i] <= '0;
      end else begin
         if (csr_valid && csr_ready) size_ff <= csr_data;
         if (accept) begin
            row_ff <= row_in;
            col_ff <= col_in;
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            s2_mask_ff <= s1_emit_ff;
            for (int r = 0; r < 3; r++) begin
               win_ff[r]   <= grid[r][1];
               win_ff[3+r] <= grid[r][2];
            end
         end else if (rsp_load) begin
            s2_mask_ff <= mask_left;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers and line store
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff  <= req_tdata;
         s1_r_ff    <= cur_r;
         s1_c_ff    <= cur_c;
         s1_emit_ff <= emit_in;
         line_rd_ff <= line_mem[cur_c[AW-1:0]];
      end
      if (s1_adv) begin
         line_mem[s1_c_ff[AW-1:0]] <= {line_rd_ff[PW-1:0], s1_pix_ff};
         for (int j = 0; j < 4; j++) begin
            s2_sum_ff[j] <= sum_in[j];
            s2_div_ff[j] <= div_in[j];
            s2_row_ff[j] <= orow_in[j];
            s2_col_ff[j] <= ocol_in[j];
         end
      end
      if (rsp_load) begin
         o_red_ff   <= rbs_pkg::div_mean(s2_sum_ff[pick][0], s2_div_ff[pick]);
         o_green_ff <= rbs_pkg::div_mean(s2_sum_ff[pick][1], s2_div_ff[pick]);
         o_blue_ff  <= rbs_pkg::div_mean(s2_sum_ff[pick][2], s2_div_ff[pick]);
         o_row_ff   <= s2_row_ff[pick];
         o_col_ff   <= s2_col_ff[pick];
         o_last_ff  <= (mask_left == '0);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, o_col_ff, o_row_ff, o_blue_ff, o_green_ff, o_red_ff};
   assign rsp_tlast  = o_last_ff;

endmodule
